// File: hdl/small_matrix_inverse_with_det_assert.svh
// Assertion macros shared by the checker
`ifndef SMALL_MATRIX_INVERSE_WITH_DET_ASSERT_SVH
`define SMALL_MATRIX_INVERSE_WITH_DET_ASSERT_SVH

// same-cycle implication
`define SMI_ASSERT_IMPL(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define SMI_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// File: hdl/smi_pkg.sv
package smi_pkg;

	localparam int MAX_ORDER = 3;
	localparam int FRAC_BITS = 16;
	localparam int DIM       = 3;
	localparam int NEL       = DIM * DIM;
	localparam int EW        = 32;               // element width
	localparam int PW        = 2 * EW;           // element product
	localparam int CW        = PW + 1;           // cofactor
	localparam int DW        = EW + CW + 2;      // determinant, full width
	localparam int NW        = CW + 2 * FRAC_BITS; // scaled numerator magnitude
	localparam int QW        = 32;               // quotient bits produced
	localparam int IN_DW     = NEL * EW;
	localparam int OUT_DW    = (NEL + 1) * EW;

	localparam logic [1:0] ORD1 = 2'd1;
	localparam logic [1:0] ORD2 = 2'd2;
	localparam logic [1:0] ORD3 = 2'd3;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_SINGULAR = 2'd1,
		ST_SAT      = 2'd2
	} status_t;

	typedef logic signed [EW-1:0] elem_t;
	typedef logic signed [PW-1:0] prod_t;
	typedef logic signed [CW-1:0] cof_t;
	typedef logic signed [CW-1:0] pp_t;
	typedef logic signed [DW-1:0] det_t;
	typedef logic [DW-1:0]        mag_t;
	typedef logic [CW-1:0]        cmag_t;
	typedef logic [QW-1:0]        quo_t;

	localparam elem_t EL_MAX = {1'b0, {(EW-1){1'b1}}};
	localparam elem_t EL_MIN = {1'b1, {(EW-1){1'b0}}};

	typedef struct packed {
		logic [1:0] order;
		logic       last;
	} side_t;

	typedef struct packed {
		logic  last;
		logic  zero;
		logic  det_sat;
		elem_t det_out;
	} rside_t;

	typedef struct packed {
		logic neg;
		logic ovf;
	} lane_t;

	typedef lane_t [NEL-1:0] lanes_t;

	// cofactor k = r*3+c is a*b - c*d over row-major element indices
	localparam int XTAB [NEL][4] = '{
		'{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
		'{6, 5, 3, 8}, '{0, 8, 6, 2}, '{2, 3, 0, 5},
		'{3, 7, 6, 4}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
	};

endpackage

// File: hdl/small_matrix_inverse_with_det.sv
// Inverse and determinant of a 1x1, 2x2 or 3x3 Q16.16 matrix, one matrix per clock
// while s_tready is high. A word on s_tdata is the matrix in column-major order;
// order comes from the cfg_wr_data register (0 acts as 1); the user must write it
// only while the block is idle, as the block itself does not enforce this.
// Data runs through the cofactor and determinant product stages, the sign and range
// stages, the restoring divider (one quotient bit per stage, nine lanes in parallel)
// and the output register. A two-entry output buffer lets input go on for one word
// after m_tready drops. m_tuser is 0 ok, 1 singular (all outputs zero), 2 saturated.
module small_matrix_inverse_with_det (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [1:0]                  cfg_wr_data,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	// elem_r0_c0, elem_r1_c0, elem_r2_c0, elem_r0_c1, ... elem_r2_c2
	input  logic [smi_pkg::IN_DW-1:0]   s_tdata,
	input  logic                        s_tlast,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// inv_r0_c0, inv_r1_c0, inv_r2_c0, inv_r0_c1, ... inv_r2_c2, determinant
	output logic [smi_pkg::OUT_DW-1:0]  m_tdata,
	// status
	output logic [1:0]                  m_tuser,
	output logic                        m_tlast
);

	localparam int EW = smi_pkg::EW;

	logic [1:0]      order_q;
	logic [1:0]      ord_c;
	logic            en;
	smi_pkg::elem_t  elem_in [smi_pkg::NEL];
	smi_pkg::side_t  side_in;

	logic            adj_vld;
	smi_pkg::cof_t   adj_cof [smi_pkg::NEL];
	smi_pkg::det_t   adj_det;
	smi_pkg::side_t  adj_side;

	logic            prep_vld;
	smi_pkg::mag_t   prep_rem [smi_pkg::NEL];
	smi_pkg::quo_t   prep_lo [smi_pkg::NEL];
	smi_pkg::lanes_t prep_flg;
	smi_pkg::mag_t   prep_dmag;
	smi_pkg::rside_t prep_rs;

	logic            div_vld;
	smi_pkg::quo_t   div_q [smi_pkg::NEL];
	smi_pkg::lanes_t div_flg;
	smi_pkg::rside_t div_rs;

	logic [smi_pkg::OUT_DW-1:0] fmt_data;
	smi_pkg::status_t           fmt_status;
	logic [smi_pkg::NEL-1:0]    lane_sat;
	smi_pkg::elem_t             lane_val [smi_pkg::NEL];

	logic                       out_vld_q, skid_vld_q;
	logic [smi_pkg::OUT_DW-1:0] out_data_q, skid_data_q;
	logic [1:0]                 out_user_q, skid_user_q;
	logic                       out_last_q, skid_last_q;
	logic                       out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q <= smi_pkg::ORD3;
		end else if (cfg_wr_en) begin
			order_q <= cfg_wr_data;
		end
	end

	always_comb begin
		priority if (order_q == 2'd0) begin
			ord_c = smi_pkg::ORD1;
		end else if (order_q > 2'(smi_pkg::MAX_ORDER)) begin
			ord_c = 2'(smi_pkg::MAX_ORDER);
		end else begin
			ord_c = order_q;
		end
		for (int r = 0; r < smi_pkg::DIM; r++) begin
			for (int c = 0; c < smi_pkg::DIM; c++) begin
				elem_in[r*smi_pkg::DIM+c] = s_tdata[(c*smi_pkg::DIM+r)*EW +: EW];
			end
		end
		side_in.order = ord_c;
		side_in.last  = s_tlast;
	end

	assign en       = !skid_vld_q;
	assign s_tready = !skid_vld_q;

	smi_adj u_adj (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (s_tvalid),
		.elem     (elem_in),
		.side_in  (side_in),
		.out_vld  (adj_vld),
		.cof      (adj_cof),
		.det      (adj_det),
		.side_out (adj_side)
	);

	smi_prep u_prep (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (adj_vld),
		.cof     (adj_cof),
		.det     (adj_det),
		.side_in (adj_side),
		.out_vld (prep_vld),
		.rem0    (prep_rem),
		.lo      (prep_lo),
		.flg     (prep_flg),
		.dmag    (prep_dmag),
		.rside   (prep_rs)
	);

	smi_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_vld    (prep_vld),
		.rem0      (prep_rem),
		.lo        (prep_lo),
		.flg_in    (prep_flg),
		.dmag      (prep_dmag),
		.rside_in  (prep_rs),
		.out_vld   (div_vld),
		.quo       (div_q),
		.flg_out   (div_flg),
		.rside_out (div_rs)
	);

	// sign and 32-bit saturation of each quotient, output packing and status code
	always_comb begin
		for (int k = 0; k < smi_pkg::NEL; k++) begin
			lane_sat[k] = 1'b0;
			priority if (div_flg[k].ovf) begin
				lane_sat[k] = 1'b1;
				lane_val[k] = div_flg[k].neg ? smi_pkg::EL_MIN : smi_pkg::EL_MAX;
			end else if (div_flg[k].neg) begin
				if (div_q[k][EW-1] && (|div_q[k][EW-2:0])) begin
					lane_sat[k] = 1'b1;
					lane_val[k] = smi_pkg::EL_MIN;
				end else begin
					lane_val[k] = -div_q[k];
				end
			end else if (div_q[k][EW-1]) begin
				lane_sat[k] = 1'b1;
				lane_val[k] = smi_pkg::EL_MAX;
			end else begin
				lane_val[k] = div_q[k];
			end
		end
		fmt_data = '0;
		if (!div_rs.zero) begin
			for (int r = 0; r < smi_pkg::DIM; r++) begin
				for (int c = 0; c < smi_pkg::DIM; c++) begin
					fmt_data[(c*smi_pkg::DIM+r)*EW +: EW] = lane_val[r*smi_pkg::DIM+c];
				end
			end
			fmt_data[smi_pkg::NEL*EW +: EW] = div_rs.det_out;
		end
		priority if (div_rs.zero) begin
			fmt_status = smi_pkg::ST_SINGULAR;
		end else if ((|lane_sat) || div_rs.det_sat) begin
			fmt_status = smi_pkg::ST_SAT;
		end else begin
			fmt_status = smi_pkg::ST_OK;
		end
	end

	assign out_free = !out_vld_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else begin
			priority if (skid_vld_q) begin
				if (out_free) begin
					out_vld_q  <= 1'b1;
					skid_vld_q <= 1'b0;
				end
			end else if (div_vld) begin
				if (out_free) begin
					out_vld_q <= 1'b1;
				end else begin
					skid_vld_q <= 1'b1;
				end
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		priority if (skid_vld_q) begin
			if (out_free) begin
				out_data_q <= skid_data_q;
				out_user_q <= skid_user_q;
				out_last_q <= skid_last_q;
			end
		end else if (div_vld) begin
			if (out_free) begin
				out_data_q <= fmt_data;
				out_user_q <= fmt_status;
				out_last_q <= div_rs.last;
			end else begin
				skid_data_q <= fmt_data;
				skid_user_q <= fmt_status;
				skid_last_q <= div_rs.last;
			end
		end else begin
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;
	assign m_tlast  = out_last_q;

endmodule

// File: hdl/smi_adj.sv
// Products, cofactors and the full-width determinant: five stages
module smi_adj (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_vld,
	input  smi_pkg::elem_t elem [smi_pkg::NEL],
	input  smi_pkg::side_t side_in,
	output logic           out_vld,
	output smi_pkg::cof_t  cof [smi_pkg::NEL],
	output smi_pkg::det_t  det,
	output smi_pkg::side_t side_out
);

	smi_pkg::prod_t pa_s1 [smi_pkg::NEL];
	smi_pkg::prod_t pb_s1 [smi_pkg::NEL];
	smi_pkg::elem_t e_s1 [smi_pkg::NEL];
	smi_pkg::side_t side_s1, side_s2, side_s3, side_s4, side_s5;
	smi_pkg::cof_t  cof_n [smi_pkg::NEL];
	smi_pkg::cof_t  cof_s2 [smi_pkg::NEL];
	smi_pkg::cof_t  cof_s3 [smi_pkg::NEL];
	smi_pkg::cof_t  cof_s4 [smi_pkg::NEL];
	smi_pkg::cof_t  cof_s5 [smi_pkg::NEL];
	smi_pkg::elem_t e0_s2 [smi_pkg::DIM];
	smi_pkg::pp_t   pl_s3 [smi_pkg::DIM];
	smi_pkg::pp_t   ph_s3 [smi_pkg::DIM];
	smi_pkg::det_t  term_s4 [smi_pkg::DIM];
	smi_pkg::det_t  det_s5;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	// order-3 cofactors taken apart per order
	always_comb begin
		for (int k = 0; k < smi_pkg::NEL; k++) begin
			cof_n[k] = smi_pkg::CW'(pa_s1[k]) - smi_pkg::CW'(pb_s1[k]);
		end
		unique case (side_s1.order)
			smi_pkg::ORD1: begin
				for (int k = 0; k < smi_pkg::NEL; k++) begin
					cof_n[k] = '0;
				end
				cof_n[0] = smi_pkg::CW'(1);
			end
			smi_pkg::ORD2: begin
				for (int k = 0; k < smi_pkg::NEL; k++) begin
					cof_n[k] = '0;
				end
				cof_n[0] = smi_pkg::CW'(e_s1[4]);
				cof_n[1] = -smi_pkg::CW'(e_s1[1]);
				cof_n[3] = -smi_pkg::CW'(e_s1[3]);
				cof_n[4] = smi_pkg::CW'(e_s1[0]);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < smi_pkg::NEL; k++) begin
				pa_s1[k] <= smi_pkg::prod_t'(elem[smi_pkg::XTAB[k][0]])
					* smi_pkg::prod_t'(elem[smi_pkg::XTAB[k][1]]);
				pb_s1[k] <= smi_pkg::prod_t'(elem[smi_pkg::XTAB[k][2]])
					* smi_pkg::prod_t'(elem[smi_pkg::XTAB[k][3]]);
				e_s1[k]  <= elem[k];
				cof_s2[k] <= cof_n[k];
				cof_s3[k] <= cof_s2[k];
				cof_s4[k] <= cof_s3[k];
				cof_s5[k] <= cof_s4[k];
			end
			// det along row 0: cofactors at (0,0), (1,0), (2,0); split high/low halves
			for (int j = 0; j < smi_pkg::DIM; j++) begin
				e0_s2[j] <= e_s1[j];
				pl_s3[j] <= smi_pkg::pp_t'(e0_s2[j])
					* smi_pkg::pp_t'($signed({1'b0, cof_s2[3*j][smi_pkg::EW-1:0]}));
				ph_s3[j] <= smi_pkg::pp_t'(e0_s2[j])
					* smi_pkg::pp_t'($signed(cof_s2[3*j][smi_pkg::CW-1:smi_pkg::EW]));
				term_s4[j] <= (smi_pkg::DW'(ph_s3[j]) <<< smi_pkg::EW)
					+ smi_pkg::DW'(pl_s3[j]);
			end
			det_s5  <= term_s4[0] + term_s4[1] + term_s4[2];
			side_s1 <= side_in;
			side_s2 <= side_s1;
			side_s3 <= side_s2;
			side_s4 <= side_s3;
			side_s5 <= side_s4;
		end
	end

	assign out_vld  = vld_s5;
	assign cof      = cof_s5;
	assign det      = det_s5;
	assign side_out = side_s5;

endmodule

// File: hdl/smi_prep.sv
// Signs, magnitudes, overflow test and the Q16.16 determinant: two stages
module smi_prep (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_vld,
	input  smi_pkg::cof_t   cof [smi_pkg::NEL],
	input  smi_pkg::det_t   det,
	input  smi_pkg::side_t  side_in,
	output logic            out_vld,
	output smi_pkg::mag_t   rem0 [smi_pkg::NEL],
	output smi_pkg::quo_t   lo [smi_pkg::NEL],
	output smi_pkg::lanes_t flg,
	output smi_pkg::mag_t   dmag,
	output smi_pkg::rside_t rside
);

	logic                   dneg;
	smi_pkg::det_t          sh;
	logic                   fits;
	smi_pkg::rside_t        rs_n;
	smi_pkg::cmag_t         cmag_s1 [smi_pkg::NEL];
	logic [smi_pkg::NEL-1:0] neg_s1;
	smi_pkg::mag_t          dmag_s1, dmag_s2;
	smi_pkg::rside_t        rside_s1, rside_s2;
	logic [smi_pkg::NW-1:0] num [smi_pkg::NEL];
	smi_pkg::mag_t          rem_s2 [smi_pkg::NEL];
	smi_pkg::quo_t          lo_s2 [smi_pkg::NEL];
	smi_pkg::lanes_t        flg_s2;
	logic vld_s1, vld_s2;

	always_comb begin
		dneg = det[smi_pkg::DW-1];
		unique case (side_in.order)
			smi_pkg::ORD1: sh = det;
			smi_pkg::ORD2: sh = det >>> smi_pkg::FRAC_BITS;
			default:       sh = det >>> (2 * smi_pkg::FRAC_BITS);
		endcase
		fits = (&sh[smi_pkg::DW-1:smi_pkg::EW-1]) | ~(|sh[smi_pkg::DW-1:smi_pkg::EW-1]);
		rs_n.last    = side_in.last;
		rs_n.zero    = (det == '0);
		rs_n.det_sat = !fits;
		rs_n.det_out = fits ? sh[smi_pkg::EW-1:0]
			: (sh[smi_pkg::DW-1] ? smi_pkg::EL_MIN : smi_pkg::EL_MAX);
	end

	always_comb begin
		for (int k = 0; k < smi_pkg::NEL; k++) begin
			num[k] = smi_pkg::NW'(cmag_s1[k]) << (2 * smi_pkg::FRAC_BITS);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < smi_pkg::NEL; k++) begin
				cmag_s1[k] <= cof[k][smi_pkg::CW-1] ? smi_pkg::cmag_t'(-cof[k])
					: smi_pkg::cmag_t'(cof[k]);
				neg_s1[k]  <= cof[k][smi_pkg::CW-1] ^ dneg;
				// quotient of 2^32 or more cannot fit: no need to divide further
				rem_s2[k]         <= smi_pkg::DW'(num[k][smi_pkg::NW-1:smi_pkg::QW]);
				lo_s2[k]          <= num[k][smi_pkg::QW-1:0];
				flg_s2[k].neg     <= neg_s1[k];
				flg_s2[k].ovf     <= smi_pkg::DW'(num[k][smi_pkg::NW-1:smi_pkg::QW]) >= dmag_s1;
			end
			dmag_s1  <= dneg ? smi_pkg::mag_t'(-det) : smi_pkg::mag_t'(det);
			dmag_s2  <= dmag_s1;
			rside_s1 <= rs_n;
			rside_s2 <= rside_s1;
		end
	end

	assign out_vld = vld_s2;
	assign rem0    = rem_s2;
	assign lo      = lo_s2;
	assign flg     = flg_s2;
	assign dmag    = dmag_s2;
	assign rside   = rside_s2;

endmodule

// File: hdl/smi_div.sv
// Restoring divider, one quotient bit per stage, nine lanes sharing the divisor
module smi_div (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_vld,
	input  smi_pkg::mag_t   rem0 [smi_pkg::NEL],
	input  smi_pkg::quo_t   lo [smi_pkg::NEL],
	input  smi_pkg::lanes_t flg_in,
	input  smi_pkg::mag_t   dmag,
	input  smi_pkg::rside_t rside_in,
	output logic            out_vld,
	output smi_pkg::quo_t   quo [smi_pkg::NEL],
	output smi_pkg::lanes_t flg_out,
	output smi_pkg::rside_t rside_out
);

	localparam int QW = smi_pkg::QW;
	localparam int DW = smi_pkg::DW;

	logic            vld_s  [QW+1];
	smi_pkg::mag_t   rem_s  [QW+1][smi_pkg::NEL];
	smi_pkg::quo_t   lo_s   [QW+1][smi_pkg::NEL];
	smi_pkg::quo_t   q_s    [QW+1][smi_pkg::NEL];
	smi_pkg::mag_t   dmag_s [QW+1];
	smi_pkg::lanes_t flg_s  [QW+1];
	smi_pkg::rside_t rs_s   [QW+1];

	always_comb begin
		vld_s[0]  = in_vld;
		dmag_s[0] = dmag;
		flg_s[0]  = flg_in;
		rs_s[0]   = rside_in;
		for (int k = 0; k < smi_pkg::NEL; k++) begin
			rem_s[0][k] = rem0[k];
			lo_s[0][k]  = lo[k];
			q_s[0][k]   = '0;
		end
	end

	for (genvar i = 0; i < QW; i++) begin : g_stg
		logic [DW:0]             t  [smi_pkg::NEL];
		logic [DW:0]             df [smi_pkg::NEL];
		logic [smi_pkg::NEL-1:0] ge;

		always_comb begin
			for (int k = 0; k < smi_pkg::NEL; k++) begin
				t[k]  = {rem_s[i][k], lo_s[i][k][QW-1]};
				df[k] = t[k] - {1'b0, dmag_s[i]};
				ge[k] = t[k] >= {1'b0, dmag_s[i]};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (en) begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int k = 0; k < smi_pkg::NEL; k++) begin
					rem_s[i+1][k] <= ge[k] ? df[k][DW-1:0] : t[k][DW-1:0];
					lo_s[i+1][k]  <= lo_s[i][k] << 1;
					q_s[i+1][k]   <= {q_s[i][k][QW-2:0], ge[k]};
				end
				dmag_s[i+1] <= dmag_s[i];
				flg_s[i+1]  <= flg_s[i];
				rs_s[i+1]   <= rs_s[i];
			end
		end
	end

	assign out_vld   = vld_s[QW];
	assign quo       = q_s[QW];
	assign flg_out   = flg_s[QW];
	assign rside_out = rs_s[QW];

endmodule

// File: hdl/smi_chk.sv
`include "small_matrix_inverse_with_det_assert.svh"

// Port-level checks on the matrix inverse block
module smi_chk (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       s_tready,
	input logic                       m_tvalid,
	input logic                       m_tready,
	input logic [smi_pkg::OUT_DW-1:0] m_tdata,
	input logic [1:0]                 m_tuser,
	input logic                       m_tlast
);

	`SMI_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))

	`SMI_ASSERT_IMPL(a_status_code, clk, arst_n, m_tvalid, m_tuser == smi_pkg::ST_OK || m_tuser == smi_pkg::ST_SINGULAR || m_tuser == smi_pkg::ST_SAT)

	// singular word carries all-zero inverse and determinant
	`SMI_ASSERT_IMPL(a_singular_zero, clk, arst_n, m_tvalid && m_tuser == smi_pkg::ST_SINGULAR, m_tdata == '0)

	// input back-pressure only follows an output stall
	`SMI_ASSERT_IMPL(a_ready_fall, clk, arst_n, $fell(s_tready), $past(m_tvalid && !m_tready))

endmodule

bind small_matrix_inverse_with_det smi_chk u_smi_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

// File: bench/tb.sv
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import smi_pkg::*;

	typedef logic signed [127:0] wide_t;

	typedef struct packed {
		logic [NEL-1:0][EW-1:0] inv;
		logic [EW-1:0]          det;
		status_t                st;
		logic                   last;
	} inv_res_t;

	typedef struct {
		logic [1:0]  order;
		elem_t       el [NEL];
		logic        last;
		logic        typed;
		logic [31:0] det;
		status_t     st;
	} stim_row_t;

	localparam int N_DIR    = 22;
	localparam int N_RAND   = 1930;
	localparam int DRAIN    = 45;
	localparam int LIMIT    = 250000;
	localparam int HOLD_LEN = 300;

	localparam elem_t ONE = 32'sh0001_0000;

	logic                clk;
	logic                arst_n;
	logic                cfg_wr_en;
	logic [1:0]          cfg_wr_data;
	logic                s_tvalid;
	logic                s_tready;
	logic [IN_DW-1:0]    s_tdata;
	logic                s_tlast;
	logic                m_tvalid;
	logic                m_tready;
	logic [OUT_DW-1:0]   m_tdata;
	logic [1:0]          m_tuser;
	logic                m_tlast;

	inv_res_t    inv_q [$];
	logic [1:0]  cur_order;
	int          fails = 0;
	int          cycles = 0;
	int          words_in;
	logic        hold_done;

	// directed words, column-major elements
	stim_row_t dir_tab [N_DIR] = '{
		'{ORD3, '{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE}, 1'b0, 1'b1, 32'h0001_0000, ST_OK},
		'{ORD3, '{0, 0, 0, 0, 0, 0, 0, 0, 0}, 1'b1, 1'b1, 32'h0, ST_SINGULAR},
		'{ORD3, '{EL_MAX, EL_MAX, EL_MAX, EL_MAX, EL_MAX, EL_MAX, EL_MAX, EL_MAX, EL_MAX},
			1'b0, 1'b1, 32'h0, ST_SINGULAR},
		'{ORD3, '{EL_MIN, EL_MIN, EL_MIN, EL_MIN, EL_MIN, EL_MIN, EL_MIN, EL_MIN, EL_MIN},
			1'b1, 1'b1, 32'h0, ST_SINGULAR},
		'{ORD3, '{EL_MAX, 0, 0, 0, EL_MAX, 0, 0, 0, EL_MAX}, 1'b0, 1'b0, 32'h0, ST_OK},
		'{ORD3, '{EL_MIN, 0, 0, 0, EL_MIN, 0, 0, 0, EL_MIN}, 1'b0, 1'b0, 32'h0, ST_OK},
		'{ORD3, '{1, 0, 0, 0, 1, 0, 0, 0, 1}, 1'b0, 1'b0, 32'h0, ST_OK},
		'{ORD3, '{-1, 0, 0, 0, 1, 0, 0, 0, 1}, 1'b0, 1'b0, 32'h0, ST_OK},
		'{ORD3, '{32'sh20000, 32'sh8000, -32'sh3000, 32'sh1000, -32'sh18000, 32'sh4000,
			32'sh7000, 32'sh2000, 32'sh30000}, 1'b1, 1'b0, 32'h0, ST_OK},
		'{ORD2, '{ONE, 0, EL_MAX, 0, ONE, EL_MIN, -1, 5, 7}, 1'b0, 1'b1, 32'h0001_0000, ST_OK},
		'{ORD2, '{ONE, 32'sh20000, 0, 32'sh20000, 32'sh40000, 0, 0, 0, 0},
			1'b1, 1'b1, 32'h0, ST_SINGULAR},
		'{ORD2, '{EL_MIN, EL_MAX, 0, EL_MAX, EL_MIN, 0, 0, 0, 0}, 1'b0, 1'b0, 32'h0, ST_OK},
		'{ORD2, '{EL_MAX, 0, 0, 0, EL_MAX, 0, 0, 0, 0}, 1'b0, 1'b0, 32'h0, ST_OK},
		'{ORD2, '{-32'sh30000, 32'sh5000, 0, 32'sh1, 32'sh8000, 0, 0, 0, 0},
			1'b1, 1'b0, 32'h0, ST_OK},
		'{ORD1, '{ONE, 3, 3, 3, 3, 3, 3, 3, 3}, 1'b0, 1'b1, 32'h0001_0000, ST_OK},
		'{ORD1, '{0, EL_MAX, 0, 0, 0, 0, 0, 0, 0}, 1'b1, 1'b1, 32'h0, ST_SINGULAR},
		'{ORD1, '{EL_MAX, 0, 0, 0, 0, 0, 0, 0, 0}, 1'b0, 1'b0, 32'h0, ST_OK},
		'{ORD1, '{EL_MIN, 0, 0, 0, 0, 0, 0, 0, 0}, 1'b0, 1'b0, 32'h0, ST_OK},
		'{ORD1, '{1, 0, 0, 0, 0, 0, 0, 0, 0}, 1'b0, 1'b0, 32'h0, ST_OK},
		'{ORD1, '{-1, 0, 0, 0, 0, 0, 0, 0, 0}, 1'b1, 1'b0, 32'h0, ST_OK},
		'{2'd0, '{32'sh20000, 9, 9, 9, 9, 9, 9, 9, 9}, 1'b0, 1'b0, 32'h0, ST_OK},
		'{2'd0, '{0, 1, 1, 1, 1, 1, 1, 1, 1}, 1'b1, 1'b1, 32'h0, ST_SINGULAR}
	};

	small_matrix_inverse_with_det u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tlast     (s_tlast),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.m_tlast     (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [31:0] clip32(input wide_t v, inout logic hit);
		wide_t hi_lim, lo_lim;
		hi_lim = wide_t'(32'h7FFF_FFFF);
		lo_lim = -(wide_t'(1) <<< 31);
		if (v > hi_lim) begin
			hit = 1'b1;
			return 32'h7FFF_FFFF;
		end
		if (v < lo_lim) begin
			hit = 1'b1;
			return 32'h8000_0000;
		end
		return v[31:0];
	endfunction

	function automatic inv_res_t invert(input logic [1:0] ord, input logic [IN_DW-1:0] mat,
			input logic lst);
		wide_t       a [3][3];
		wide_t       cf [3][3];
		wide_t       dt, num, qs;
		logic [127:0] dmag, nmag, quo;
		logic        hit;
		int          n;
		inv_res_t    res;
		res = '0;
		res.last = lst;
		hit = 1'b0;
		n = (ord == 2'd0) ? 1 : int'(ord);
		for (int k = 0; k < NEL; k++) begin
			a[k % 3][k / 3] = wide_t'($signed(mat[k*EW +: EW]));
			cf[k % 3][k / 3] = '0;
		end
		if (n == 1) begin
			cf[0][0] = 1;
			dt = a[0][0];
		end else if (n == 2) begin
			cf[0][0] = a[1][1];
			cf[1][0] = -a[1][0];
			cf[0][1] = -a[0][1];
			cf[1][1] = a[0][0];
			dt = a[0][0] * a[1][1] - a[0][1] * a[1][0];
		end else begin
			cf[0][0] = a[1][1] * a[2][2] - a[1][2] * a[2][1];
			cf[1][0] = a[2][0] * a[1][2] - a[1][0] * a[2][2];
			cf[2][0] = a[1][0] * a[2][1] - a[2][0] * a[1][1];
			cf[0][1] = a[0][2] * a[2][1] - a[0][1] * a[2][2];
			cf[1][1] = a[0][0] * a[2][2] - a[2][0] * a[0][2];
			cf[2][1] = a[0][1] * a[2][0] - a[0][0] * a[2][1];
			cf[0][2] = a[0][1] * a[1][2] - a[0][2] * a[1][1];
			cf[1][2] = a[0][2] * a[1][0] - a[0][0] * a[1][2];
			cf[2][2] = a[0][0] * a[1][1] - a[0][1] * a[1][0];
			dt = a[0][0] * cf[0][0] + a[0][1] * cf[1][0] + a[0][2] * cf[2][0];
		end
		if (dt == 0) begin
			res.st = ST_SINGULAR;
			return res;
		end
		dmag = (dt < 0) ? -dt : dt;
		for (int r = 0; r < n; r++)
			for (int c = 0; c < n; c++) begin
				num = cf[r][c] <<< (2 * FRAC_BITS);
				nmag = (num < 0) ? -num : num;
				quo = nmag / dmag;
				qs = ((num < 0) != (dt < 0)) ? -wide_t'(quo) : wide_t'(quo);
				res.inv[c*3 + r] = clip32(qs, hit);
			end
		res.det = clip32(dt >>> ((n - 1) * FRAC_BITS), hit);
		res.st = hit ? ST_SAT : ST_OK;
		return res;
	endfunction

	function automatic elem_t rand_elem(input int kind);
		case (kind)
			0: return elem_t'($urandom);
			1: return elem_t'($urandom_range(0, 32'h3FFFF)) - 32'sh20000;
			default: begin
				case ($urandom_range(0, 4))
					0: return EL_MAX;
					1: return EL_MIN;
					2: return 0;
					3: return ONE;
					default: return -ONE;
				endcase
			end
		endcase
	endfunction

	function automatic logic idle_now();
		if (words_in >= 1000 && words_in < 1400)
			return 1'b0;
		return ($urandom_range(0, 99) < 10);
	endfunction

	// hand one word over and log what should come back
	task automatic send_word(input logic [IN_DW-1:0] mat, input logic lst, input logic typed,
			input logic [31:0] tdet, input status_t tst);
		inv_res_t exp_r;
		while (idle_now()) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= mat;
		s_tlast  <= lst;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		exp_r = invert(cur_order, mat, lst);
		if (typed) begin
			exp_r.det = tdet;
			exp_r.st  = tst;
		end
		inv_q.push_back(exp_r);
		words_in++;
	endtask

	task automatic set_order(input logic [1:0] ord);
		s_tvalid <= 1'b0;
		while (inv_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= ord;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		cur_order = ord;
	endtask

	// sender
	initial begin
		logic [IN_DW-1:0] mat;
		logic [1:0]       ord_seq [6];
		int               kind, n;
		ord_seq = '{ORD3, ORD2, ORD1, 2'd0, ORD3, ORD2};
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		words_in = 0;
		cur_order = ORD3;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_DIR; i++) begin
			if (dir_tab[i].order != cur_order)
				set_order(dir_tab[i].order);
			for (int k = 0; k < NEL; k++)
				mat[k*EW +: EW] = dir_tab[i].el[k];
			send_word(mat, dir_tab[i].last, dir_tab[i].typed, dir_tab[i].det, dir_tab[i].st);
		end

		for (int i = 0; i < N_RAND; i++) begin
			if (i % 322 == 0)
				set_order(ord_seq[i / 322]);
			kind = $urandom_range(0, 9);
			for (int k = 0; k < NEL; k++)
				mat[k*EW +: EW] = rand_elem(kind < 6 ? 1 : (kind < 8 ? 0 : 2));
			if (kind == 9) begin
				// make it singular: duplicate column 0 into the last used column (order 1: zero element 0)
				n = (cur_order == 2'd0) ? 1 : int'(cur_order);
				if (n == 1)
					mat[0 +: EW] = '0;
				else
					mat[(n - 1)*3*EW +: 3*EW] = mat[0 +: 3*EW];
			end
			send_word(mat, ($urandom_range(0, 3) == 0), 1'b0, 32'h0, ST_OK);
		end
		s_tvalid <= 1'b0;

		while (inv_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
		if (fails == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// receiver back-pressure, with one long hold once the pipe is busy
	initial begin
		m_tready = 1'b0;
		hold_done = 1'b0;
		forever begin
			@(posedge clk);
			if (!hold_done && words_in >= 600) begin
				m_tready <= 1'b0;
				repeat (HOLD_LEN) @(posedge clk);
				hold_done = 1'b1;
				m_tready <= 1'b1;
			end else begin
				m_tready <= !idle_now();
			end
		end
	end

	always @(posedge clk) begin
		inv_res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (inv_q.size() == 0) begin
				$error("unexpected word on output");
				fails++;
			end else begin
				want = inv_q.pop_front();
				for (int k = 0; k < NEL; k++)
					if (m_tdata[k*EW +: EW] !== want.inv[k]) begin
						$error("inv[%0d] (r%0d c%0d): expected %h, got %h", k, k % 3, k / 3,
							want.inv[k], m_tdata[k*EW +: EW]);
						fails++;
					end
				if (m_tdata[NEL*EW +: EW] !== want.det) begin
					$error("determinant: expected %h, got %h", want.det,
						m_tdata[NEL*EW +: EW]);
					fails++;
				end
				if (m_tuser !== want.st) begin
					$error("status: expected %0d, got %0d", want.st, m_tuser);
					fails++;
				end
				if (m_tlast !== want.last) begin
					$error("last_out: expected %b, got %b", want.last, m_tlast);
					fails++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

endmodule

`default_nettype wire
